// ===== rtl/core/alb_pkg.sv =====
// Shared types and constants for the alarm LED blink/breathe indicator.
// No dependencies; imported by every module in rtl/core.
package alb_pkg;

	localparam int unsigned DATA_W  = 16;
	localparam int unsigned CFG_IDX_W = 3;

	// register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PWM_PERIOD      = 3'd0,
		REG_BLINK_INTERVAL  = 3'd1,
		REG_BLINK_DURATION  = 3'd2,
		REG_BREATH_STEP     = 3'd3,
		REG_BREATH_PEAK     = 3'd4
	} reg_idx_t;

	localparam logic [DATA_W-1:0] RST_PWM_PERIOD     = 16'd720;
	localparam logic [DATA_W-1:0] RST_BLINK_INTERVAL = 16'd500;
	localparam logic [DATA_W-1:0] RST_BLINK_DURATION = 16'd5000;
	localparam logic [DATA_W-1:0] RST_BREATH_STEP    = 16'd20;
	localparam logic [DATA_W-1:0] RST_BREATH_PEAK    = 16'd50;

	// input item kinds
	localparam logic KIND_TICK   = 1'b0;
	localparam logic KIND_UPDATE = 1'b1;

	typedef struct packed {
		logic [DATA_W-1:0] pwm_period;
		logic [DATA_W-1:0] blink_interval;
		logic [DATA_W-1:0] blink_duration;
		logic [DATA_W-1:0] breath_step_interval;
		logic [DATA_W-1:0] breath_peak;
	} cfg_t;

	typedef struct packed {
		logic              kind;
		logic [DATA_W-1:0] alarm_value;
	} item_t;

	typedef struct packed {
		logic              compare_write;
		logic [DATA_W-1:0] compare_value;
	} result_t;

endpackage

// ===== rtl/core/alarm_led_blink_then_breathe.sv =====
// Top level of the alarm LED indicator: input register, state/update core,
// result register. Depends on alb_pkg, alb_cfg_regs and alb_core.

// One item (tick or alarm update) is taken every clock cycle while in_ready is high
// and yields exactly one result, compare_write/compare_value. The item waits in the
// input register and its result in the result register, with the indicator
// state updated as the item moves between them. Stalls on the output back up
// through both registers; input ready stays high while the result register is
// empty or being drained. Configuration writes are accepted in every cycle.
module alarm_led_blink_then_breathe
	import alb_pkg::*;
#(
	parameter int unsigned COUNTER_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 kind,
	input  logic [DATA_W-1:0]    alarm_value,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 compare_write,
	output logic [DATA_W-1:0]    compare_value
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1, valid_s2;
	result_t res_comb, res_s2;
	logic    advance;

	alb_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// result register free or being emptied this cycle
	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;

	alb_core #(
		.COUNTER_BITS (COUNTER_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (valid_s1 && advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (advance)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.kind        <= kind;
			item_s1.alarm_value <= alarm_value;
		end
		if (valid_s1 && advance)
			res_s2 <= res_comb;
	end

	assign out_valid     = valid_s2;
	assign compare_write = res_s2.compare_write;
	assign compare_value = res_s2.compare_value;

	// a result without a compare write carries zero
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !compare_write |-> compare_value == '0)
		else $error("idle result with nonzero compare value");

	// an empty result register never blocks the input side
	assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> in_ready)
		else $error("input stalled with empty result register");

	// every input transfer lands in the input register
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted item lost from input register");

	// a stalled input register keeps its item
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("stalled input register changed");

endmodule

// ===== rtl/core/alb_cfg_regs.sv =====
// Configuration register file: five 16-bit registers behind a valid/ready
// write channel. Depends on alb_pkg.
module alb_cfg_regs
	import alb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pwm_period           <= RST_PWM_PERIOD;
			cfg_q.blink_interval       <= RST_BLINK_INTERVAL;
			cfg_q.blink_duration       <= RST_BLINK_DURATION;
			cfg_q.breath_step_interval <= RST_BREATH_STEP;
			cfg_q.breath_peak          <= RST_BREATH_PEAK;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_PWM_PERIOD:     cfg_q.pwm_period           <= cfg_data;
				REG_BLINK_INTERVAL: cfg_q.blink_interval       <= cfg_data;
				REG_BLINK_DURATION: cfg_q.blink_duration       <= cfg_data;
				REG_BREATH_STEP:    cfg_q.breath_step_interval <= cfg_data;
				REG_BREATH_PEAK:    cfg_q.breath_peak          <= cfg_data;
				default: ;	// unmapped index: transfer is dropped
			endcase
		end
	end

endmodule

// ===== rtl/core/alb_core.sv =====
// Indicator state (arm, mode, counters, pulse level) and the per-item
// update logic producing one result. Depends on alb_pkg.
module alb_core
	import alb_pkg::*;
#(
	parameter int unsigned COUNTER_BITS = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,     // commit the item below
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t result
);

	localparam int unsigned CMP_W = (COUNTER_BITS > DATA_W) ? COUNTER_BITS : DATA_W;

	logic                    armed_q, breathing_q, led_lit_q, falling_q;
	logic [COUNTER_BITS-1:0] blink_cnt_q, alarm_cnt_q, breath_cnt_q;
	logic [DATA_W-1:0]       pulse_q;

	logic                    armed_d, breathing_d, led_lit_d, falling_d;
	logic [COUNTER_BITS-1:0] blink_cnt_d, alarm_cnt_d, breath_cnt_d;
	logic [DATA_W-1:0]       pulse_d;

	function automatic logic [COUNTER_BITS-1:0] sat_inc(input logic [COUNTER_BITS-1:0] c);
		return (&c) ? c : c + 1'b1;
	endfunction

	// count >= threshold with both sides widened to a common width
	function automatic logic reached(input logic [COUNTER_BITS-1:0] c,
	                                 input logic [DATA_W-1:0] thr);
		logic [CMP_W-1:0] cw, tw;
		cw = CMP_W'(c);
		tw = CMP_W'(thr);
		return cw >= tw;
	endfunction

	always_comb begin
		armed_d      = armed_q;
		breathing_d  = breathing_q;
		led_lit_d    = led_lit_q;
		falling_d    = falling_q;
		blink_cnt_d  = blink_cnt_q;
		alarm_cnt_d  = alarm_cnt_q;
		breath_cnt_d = breath_cnt_q;
		pulse_d      = pulse_q;
		result       = '0;

		if (item.kind == KIND_UPDATE) begin
			if (item.alarm_value != '0) begin
				armed_d     = 1'b1;
				breathing_d = 1'b0;
			end else begin
				armed_d              = 1'b0;
				alarm_cnt_d          = '0;
				result.compare_write = 1'b1;
			end
		end else begin
			blink_cnt_d  = sat_inc(blink_cnt_q);
			alarm_cnt_d  = sat_inc(alarm_cnt_q);
			breath_cnt_d = sat_inc(breath_cnt_q);
			if (armed_q) begin
				if (!breathing_q) begin
					if (reached(blink_cnt_d, cfg.blink_interval)) begin
						blink_cnt_d          = '0;
						led_lit_d            = !led_lit_q;
						result.compare_write = 1'b1;
						result.compare_value = led_lit_q ? '0 : (cfg.pwm_period >> 1);
					end
					if (reached(alarm_cnt_d, cfg.blink_duration)) begin
						alarm_cnt_d  = '0;
						breath_cnt_d = '0;
						breathing_d  = 1'b1;
					end
				end else if (reached(breath_cnt_d, cfg.breath_step_interval)) begin
					alarm_cnt_d  = '0;
					breath_cnt_d = '0;
					pulse_d      = falling_q ? pulse_q - 1'b1 : pulse_q + 1'b1;
					if (pulse_d >= cfg.breath_peak)
						falling_d = 1'b1;
					if (pulse_d == '0)
						falling_d = 1'b0;
					result.compare_write = 1'b1;
					result.compare_value = pulse_d;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q      <= 1'b0;
			breathing_q  <= 1'b0;
			led_lit_q    <= 1'b0;
			falling_q    <= 1'b0;
			blink_cnt_q  <= '0;
			alarm_cnt_q  <= '0;
			breath_cnt_q <= '0;
			pulse_q      <= '0;
		end else if (step) begin
			armed_q      <= armed_d;
			breathing_q  <= breathing_d;
			led_lit_q    <= led_lit_d;
			falling_q    <= falling_d;
			blink_cnt_q  <= blink_cnt_d;
			alarm_cnt_q  <= alarm_cnt_d;
			breath_cnt_q <= breath_cnt_d;
			pulse_q      <= pulse_d;
		end
	end

endmodule

// ===== tb/tb_alarm_led_blink_then_breathe.sv =====
// Self-checking testbench for the alarm LED blink/breathe indicator: drives ticks and
// alarm updates with random idling on both sides and checks every compare result.
// Depends on alb_pkg and alarm_led_blink_then_breathe.
module tb_alarm_led_blink_then_breathe;
	import alb_pkg::*;

	localparam int unsigned CNT_W = 16;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_PWM_PERIOD;
	logic [DATA_W-1:0]    cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 kind = KIND_TICK;
	logic [DATA_W-1:0]    alarm_value = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 compare_write;
	logic [DATA_W-1:0]    compare_value;

	alarm_led_blink_then_breathe #(
		.COUNTER_BITS(CNT_W)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.alarm_value  (alarm_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.compare_write(compare_write),
		.compare_value(compare_value)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// indicator shadow state
	cfg_t             ind_cfg;
	logic             armed, breathing, led_lit, falling;
	logic [CNT_W-1:0] blink_cnt, alarm_cnt, breath_cnt;
	logic [DATA_W-1:0] pulse;

	item_t   pending[$];
	result_t compare_due[$];
	item_t   nxt_item, seen_item;
	result_t want;

	int unsigned in_gap, in_gap_max = 0;
	int unsigned out_hold, out_stall, out_stall_max = 0;
	int unsigned n_items = 0, n_results = 0, n_writes = 0, n_cfg = 0, errors = 0;

	task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] exp_val);
		$display("MISMATCH %s: got %0h expected %0h (result %0d)", what, got, exp_val,
			n_results);
		errors++;
	endtask

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		return (&c) ? c : c + 1'b1;
	endfunction

	function automatic result_t advance_indicator(input item_t it);
		result_t r;
		r = '0;
		if (it.kind == KIND_UPDATE) begin
			if (it.alarm_value != '0) begin
				armed = 1'b1;
				breathing = 1'b0;
			end else begin
				armed = 1'b0;
				alarm_cnt = '0;
				r.compare_write = 1'b1;
			end
		end else begin
			blink_cnt = sat_inc(blink_cnt);
			alarm_cnt = sat_inc(alarm_cnt);
			breath_cnt = sat_inc(breath_cnt);
			if (armed) begin
				if (!breathing) begin
					if (blink_cnt >= ind_cfg.blink_interval) begin
						blink_cnt = '0;
						led_lit = !led_lit;
						r.compare_write = 1'b1;
						r.compare_value = led_lit ? (ind_cfg.pwm_period >> 1) : '0;
					end
					// toggle and mode switch may both fire; the blink value stands
					if (alarm_cnt >= ind_cfg.blink_duration) begin
						alarm_cnt = '0;
						breath_cnt = '0;
						breathing = 1'b1;
					end
				end else if (breath_cnt >= ind_cfg.breath_step_interval) begin
					alarm_cnt = '0;
					breath_cnt = '0;
					pulse = falling ? pulse - 1'b1 : pulse + 1'b1;
					if (pulse >= ind_cfg.breath_peak)
						falling = 1'b1;
					if (pulse == '0)
						falling = 1'b0;
					r.compare_write = 1'b1;
					r.compare_value = pulse;
				end
			end
		end
		return r;
	endfunction

	// scoreboard: check results first, then predict on input transfers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ind_cfg.pwm_period <= RST_PWM_PERIOD;
			ind_cfg.blink_interval <= RST_BLINK_INTERVAL;
			ind_cfg.blink_duration <= RST_BLINK_DURATION;
			ind_cfg.breath_step_interval <= RST_BREATH_STEP;
			ind_cfg.breath_peak <= RST_BREATH_PEAK;
			armed = 1'b0;
			breathing = 1'b0;
			led_lit = 1'b0;
			falling = 1'b0;
			blink_cnt = '0;
			alarm_cnt = '0;
			breath_cnt = '0;
			pulse = '0;
			compare_due.delete();
		end else begin
			if (out_valid && out_ready) begin
				n_results++;
				if (compare_write)
					n_writes++;
				if (compare_due.size() == 0) begin
					report_mismatch("result with nothing pending", compare_value, '0);
				end else begin
					want = compare_due.pop_front();
					if (compare_write !== want.compare_write)
						report_mismatch("compare_write", DATA_W'(compare_write),
							DATA_W'(want.compare_write));
					if (compare_value !== want.compare_value)
						report_mismatch("compare_value", compare_value, want.compare_value);
				end
			end
			if (cfg_valid && cfg_ready) begin
				n_cfg++;
				case (cfg_index)
					REG_PWM_PERIOD:     ind_cfg.pwm_period <= cfg_data;
					REG_BLINK_INTERVAL: ind_cfg.blink_interval <= cfg_data;
					REG_BLINK_DURATION: ind_cfg.blink_duration <= cfg_data;
					REG_BREATH_STEP:    ind_cfg.breath_step_interval <= cfg_data;
					REG_BREATH_PEAK:    ind_cfg.breath_peak <= cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				n_items++;
				seen_item.kind = kind;
				seen_item.alarm_value = alarm_value;
				compare_due.push_back(advance_indicator(seen_item));
			end
		end
	end

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			kind <= KIND_TICK;
			alarm_value <= '0;
			in_gap <= 0;
		end else if (!in_valid || in_ready) begin
			if (in_gap != 0) begin
				in_valid <= 1'b0;
				in_gap <= in_gap - 1;
			end else if (pending.size() != 0) begin
				nxt_item = pending.pop_front();
				kind <= nxt_item.kind;
				alarm_value <= nxt_item.alarm_value;
				in_valid <= 1'b1;
				in_gap <= $urandom_range(0, in_gap_max);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result sink with per-transfer stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_hold <= 0;
		end else if (out_hold != 0) begin
			out_hold <= out_hold - 1;
		end else if (out_valid && out_ready) begin
			out_stall = $urandom_range(0, out_stall_max);
			out_ready <= (out_stall == 0);
			out_hold <= (out_stall == 0) ? 0 : out_stall - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic queue_tick();
		item_t it;
		it.kind = KIND_TICK;
		it.alarm_value = 16'($urandom);
		pending.push_back(it);
	endtask

	task automatic queue_update(input logic [DATA_W-1:0] val);
		item_t it;
		it.kind = KIND_UPDATE;
		it.alarm_value = val;
		pending.push_back(it);
	endtask

	// waits until every result is back, then lets the pipeline settle
	task automatic drain();
		do @(negedge clk);
		while (pending.size() != 0 || in_valid || compare_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_reg(input reg_idx_t idx, input logic [DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk);
		while (!cfg_ready);
	endtask

	// called at a rising edge while idle; valid stays high across the five transfers
	task automatic load_cfg(input logic [DATA_W-1:0] period, interval, duration, step,
			peak);
		send_reg(REG_PWM_PERIOD, period);
		send_reg(REG_BLINK_INTERVAL, interval);
		send_reg(REG_BLINK_DURATION, duration);
		send_reg(REG_BREATH_STEP, step);
		send_reg(REG_BREATH_PEAK, peak);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [DATA_W-1:0] pick_small(input int unsigned hi);
		return ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(0, hi));
	endfunction

	function automatic int unsigned pick_idle();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 3;
			default: return 16;
		endcase
	endfunction

	initial begin
		logic [DATA_W-1:0] period;
		int unsigned n, r;

		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// reset registers: disarm, ignored alarm field, arm, rearm
		in_gap_max = 16;
		out_stall_max = 16;
		queue_update(16'h0000);
		queue_tick();
		queue_update(16'hFFFF);
		queue_update(16'h0001);
		queue_tick();
		drain();

		// fast blink, short duration: toggles every tick, quick switch to breathing
		load_cfg(16'hFFFF, 16'd1, 16'd3, 16'd1, 16'd2);
		@(negedge clk);
		queue_update(16'h8000);
		repeat (6) queue_tick();
		queue_update(16'h0001);
		repeat (2) queue_tick();
		queue_update(16'h0000);
		queue_tick();
		drain();

		// all-zero registers: the first tick toggles and switches to breathing, then each tick steps the pulse
		load_cfg(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		@(negedge clk);
		queue_update(16'h7FFF);
		repeat (5) queue_tick();
		queue_update(16'h0000);
		drain();

		// disarmed ticks, then a back-to-back armed stream through blink and breathing
		load_cfg(16'd1001, 16'd4, 16'd8, 16'd3, 16'd5);
		@(negedge clk);
		in_gap_max = 0;
		out_stall_max = 0;
		queue_update(16'h0000);
		repeat (6) queue_tick();
		queue_update(16'hA5A5);
		repeat (30) queue_tick();
		drain();

		// random phases: mostly armed tick streams, some rearm/disarm noise
		repeat (12) begin
			case ($urandom_range(0, 3))
				0: period = 16'h0000;
				1: period = 16'hFFFF;
				default: period = 16'($urandom);
			endcase
			load_cfg(period, pick_small(6), pick_small(40), pick_small(5), pick_small(10));
			@(negedge clk);
			in_gap_max = pick_idle();
			out_stall_max = pick_idle();
			queue_update(16'($urandom_range(1, 16'hFFFF)));
			n = $urandom_range(36, 44);
			repeat (n) begin
				r = $urandom_range(0, 99);
				if (r < 6)
					queue_update(16'($urandom_range(1, 16'hFFFF)));
				else if (r < 10)
					queue_update(16'h0000);
				else if (r < 12)
					queue_update(16'($urandom));
				else
					queue_tick();
			end
			drain();
		end

		$display("Ran %0d items through %0d register writes; %0d results, %0d compare writes",
			n_items, n_cfg, n_results, n_writes);
		$display("Covered blink, breathing, rearm and disarm, zero and max registers");
		if (errors == 0 && compare_due.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#(12 * 600_000);
		$display("Some tests failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/alb_pkg.sv
rtl/core/alb_cfg_regs.sv
rtl/core/alb_core.sv
rtl/core/alarm_led_blink_then_breathe.sv
tb/tb_alarm_led_blink_then_breathe.sv
